// ----- sv/leb_pkg.sv -----
package leb_pkg;

    localparam int MAX_CHARS_DEF = 256;
    localparam int CHAR_W        = 16;
    localparam int LEN_W         = 9;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd256;

    typedef enum logic [3:0] {
        CMD_INSERT    = 4'd0,
        CMD_BACKSPACE = 4'd1,
        CMD_LEFT      = 4'd2,
        CMD_RIGHT     = 4'd3,
        CMD_HOME      = 4'd4,
        CMD_END       = 4'd5,
        CMD_SETSEL    = 4'd6,
        CMD_CLEARSEL  = 4'd7,
        CMD_DELSEL    = 4'd8,
        CMD_SELALL    = 4'd9,
        CMD_COPY      = 4'd10,
        CMD_CUT       = 4'd11,
        CMD_PASTE     = 4'd12,
        CMD_SUBMIT    = 4'd13,
        CMD_CANCEL    = 4'd14,
        CMD_READ      = 4'd15
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_ACTIVE    = 2'd0,
        MODE_SUBMITTED = 2'd1,
        MODE_CANCELLED = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_SHL  = 2'd1,
        OP_INS  = 2'd2
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_DEL   = 3'd1,
        ST_INS   = 3'd2,
        ST_PCHK  = 3'd3,
        ST_PASTE = 3'd4,
        ST_COPY  = 3'd5,
        ST_READ  = 3'd6,
        ST_FIN   = 3'd7
    } state_t;

endpackage

// ----- sv/leb_cell.sv -----
module leb_cell #(
    parameter int W   = 16,
    parameter int XW  = 9,
    parameter int IDX = 0
) (
    input  logic               aclk,
    input  leb_pkg::cell_op_t  op,
    input  logic [XW-1:0]      base,
    input  logic [W-1:0]       din,
    input  logic [W-1:0]       left,
    input  logic [W-1:0]       right,
    output logic [W-1:0]       q
);

    localparam logic [XW-1:0] MY_IDX = XW'(IDX);

    logic [W-1:0] q_reg;
    logic [W-1:0] q_next;

    // Shift-left pulls from the right neighbor at and above base; insert opens
    // a gap at base by pulling from the left neighbor above it.
    always_comb begin
        q_next = q_reg;
        case (op)
            leb_pkg::OP_SHL: begin
                if (MY_IDX >= base) q_next = right;
            end
            leb_pkg::OP_INS: begin
                if (MY_IDX > base) q_next = left;
                else if (MY_IDX == base) q_next = din;
            end
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- sv/line_edit_buffer_top.sv -----
// Cursor, selection and session commands go straight from the input beat to the result state.
// Insert first shifts any selected characters out of the text, then writes the new character.
// Backspace and delete shift the removed characters out of the text cell chain.
// Read turns the text one lap, copy turns it two laps, paste turns the clipboard one lap.
// One command is worked at a time, stepping through the text and clipboard cell chains.
// Reset (aresetn low, synchronous) empties text and clipboard lengths, clears the session.
module line_edit_buffer_top #(
    parameter int MAX_CHARS = leb_pkg::MAX_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: char_code[15:0], sel_a[24:16], sel_b[33:25], read_index[41:34]
    input  logic [47:0] s_tdata,
    // tuser: kind[3:0]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: accepted[0], session_state[2:1], text_length[11:3], cursor_pos[20:12],
    // sel_lo[29:21], sel_hi[38:30], all_selected[39], clip_length[48:40],
    // read_char[64:49]
    output logic [71:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    localparam int PW = $clog2(MAX_CHARS + 1);
    localparam int XW = (PW > leb_pkg::LEN_W) ? PW : leb_pkg::LEN_W;
    localparam int CW = XW + 1;
    localparam int DW = leb_pkg::CHAR_W;
    localparam logic [XW-1:0] MAXP      = XW'(MAX_CHARS);
    localparam logic [CW-1:0] LAST_ONE  = CW'(MAX_CHARS - 1);
    localparam logic [CW-1:0] LAST_TWO  = CW'(2 * MAX_CHARS - 1);

    leb_pkg::state_t state_reg, state_next;
    leb_pkg::cmd_t   kind_reg;
    leb_pkg::mode_t  mode_reg, mode_next;

    logic [DW-1:0] ch_reg;
    logic [7:0]    ridx_reg;
    logic          acc_reg, acc_next;
    logic [DW-1:0] rch_reg, rch_next;
    logic [XW-1:0] len_reg, len_next, cur_reg, cur_next;
    logic [XW-1:0] ss_reg, ss_next, se_reg, se_next, clip_reg, clip_next;
    logic          all_reg, all_next;
    logic [XW-1:0] base_reg, base_next, n_reg, n_next, s_reg, s_next, e_reg, e_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          cutdel_reg, cutdel_next;
    logic [8:0]    maxlen_reg;
    logic          m_tvalid_reg;
    logic [71:0]   m_tdata_reg;

    leb_pkg::cell_op_t t_op, c_op;
    logic [XW-1:0]     t_base;
    logic [DW-1:0]     t_din, c_tail;
    logic [DW-1:0]     tq [MAX_CHARS];
    logic [DW-1:0]     cq [MAX_CHARS];

    logic          in_fire, active, del_go;
    leb_pkg::cmd_t kind_in;
    logic [XW-1:0] a_in, b_in, a_c, b_c, lo_c, hi_c, hi_cl, dn;
    logic [XW-1:0] cs, ce, lim, room, pn, pos_c, bpos;
    logic [XW-1:0] mx_ext;

    assign s_tready  = (state_reg == leb_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign kind_in   = leb_pkg::cmd_t'(s_tuser[3:0]);
    assign active    = (mode_reg == leb_pkg::MODE_ACTIVE);
    assign cfg_ready = 1'b1;

    assign a_in   = XW'(s_tdata[24:16]);
    assign b_in   = XW'(s_tdata[33:25]);
    assign a_c    = (a_in > len_reg) ? len_reg : a_in;
    assign b_c    = (b_in > len_reg) ? len_reg : b_in;
    assign lo_c   = (ss_reg < se_reg) ? ss_reg : se_reg;
    assign hi_c   = (ss_reg < se_reg) ? se_reg : ss_reg;
    assign hi_cl  = (hi_c > len_reg) ? len_reg : hi_c;
    assign del_go = (ss_reg != se_reg) && (lo_c <= len_reg);
    assign dn     = hi_cl - lo_c;

    always_comb begin
        cs = all_reg ? '0 : lo_c;
        ce = all_reg ? len_reg : hi_cl;
        if (cs > ce) cs = ce;
    end

    assign mx_ext = XW'(maxlen_reg);
    assign lim    = (mx_ext == '0) ? XW'(1) : ((mx_ext > MAXP) ? MAXP : mx_ext);
    assign room   = (len_reg < lim) ? (lim - len_reg) : '0;
    assign pn     = (clip_reg > room) ? room : clip_reg;
    assign pos_c  = (cur_reg > len_reg) ? len_reg : cur_reg;
    assign bpos   = ((cur_reg - XW'(1)) >= len_reg) ? (len_reg - XW'(1)) : (cur_reg - XW'(1));

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        rch_next    = rch_reg;
        len_next    = len_reg;
        cur_next    = cur_reg;
        ss_next     = ss_reg;
        se_next     = se_reg;
        all_next    = all_reg;
        clip_next   = clip_reg;
        base_next   = base_reg;
        n_next      = n_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        cnt_next    = cnt_reg;
        cutdel_next = cutdel_reg;
        t_op        = leb_pkg::OP_HOLD;
        t_base      = '0;
        t_din       = ch_reg;
        c_op        = leb_pkg::OP_HOLD;
        c_tail      = cq[0];

        case (state_reg)
            leb_pkg::ST_IDLE: begin
                if (in_fire) begin
                    acc_next   = active;
                    rch_next   = '0;
                    cnt_next   = '0;
                    state_next = leb_pkg::ST_FIN;
                    case (kind_in)
                        leb_pkg::CMD_INSERT, leb_pkg::CMD_PASTE: begin
                            if (active && (kind_in == leb_pkg::CMD_INSERT || clip_reg != '0)) begin
                                state_next = (kind_in == leb_pkg::CMD_INSERT) ?
                                             leb_pkg::ST_INS : leb_pkg::ST_PCHK;
                                if (all_reg) begin
                                    len_next = '0;
                                    cur_next = '0;
                                    ss_next  = '0;
                                    se_next  = '0;
                                    all_next = 1'b0;
                                end else if (del_go) begin
                                    len_next = len_reg - dn;
                                    cur_next = lo_c;
                                    ss_next  = '0;
                                    se_next  = '0;
                                    all_next = 1'b0;
                                    base_next = lo_c;
                                    n_next    = dn;
                                    if (dn != '0) state_next = leb_pkg::ST_DEL;
                                end
                            end
                        end
                        leb_pkg::CMD_BACKSPACE: begin
                            if (active) begin
                                if (all_reg) begin
                                    len_next = '0;
                                    cur_next = '0;
                                    ss_next  = '0;
                                    se_next  = '0;
                                    all_next = 1'b0;
                                end else if (ss_reg != se_reg) begin
                                    if (del_go) begin
                                        len_next  = len_reg - dn;
                                        cur_next  = lo_c;
                                        ss_next   = '0;
                                        se_next   = '0;
                                        all_next  = 1'b0;
                                        base_next = lo_c;
                                        n_next    = dn;
                                        if (dn != '0) state_next = leb_pkg::ST_DEL;
                                    end
                                end else if (cur_reg == '0 || len_reg == '0) begin
                                    acc_next = 1'b0;
                                end else begin
                                    len_next   = len_reg - XW'(1);
                                    cur_next   = bpos;
                                    base_next  = bpos;
                                    n_next     = XW'(1);
                                    state_next = leb_pkg::ST_DEL;
                                end
                            end
                        end
                        leb_pkg::CMD_LEFT: begin
                            if (active) begin
                                all_next = 1'b0;
                                if (cur_reg != '0) cur_next = cur_reg - XW'(1);
                            end
                        end
                        leb_pkg::CMD_RIGHT: begin
                            if (active) begin
                                all_next = 1'b0;
                                if (cur_reg < len_reg) cur_next = cur_reg + XW'(1);
                            end
                        end
                        leb_pkg::CMD_HOME: begin
                            if (active) begin
                                all_next = 1'b0;
                                cur_next = '0;
                            end
                        end
                        leb_pkg::CMD_END: begin
                            if (active) begin
                                all_next = 1'b0;
                                cur_next = len_reg;
                            end
                        end
                        leb_pkg::CMD_SETSEL: begin
                            if (active) begin
                                ss_next  = (a_c < b_c) ? a_c : b_c;
                                se_next  = (a_c < b_c) ? b_c : a_c;
                                all_next = 1'b0;
                            end
                        end
                        leb_pkg::CMD_CLEARSEL: begin
                            ss_next  = '0;
                            se_next  = '0;
                            all_next = 1'b0;
                            acc_next = 1'b1;
                        end
                        leb_pkg::CMD_DELSEL: begin
                            if (active && del_go) begin
                                len_next  = len_reg - dn;
                                cur_next  = lo_c;
                                ss_next   = '0;
                                se_next   = '0;
                                all_next  = 1'b0;
                                base_next = lo_c;
                                n_next    = dn;
                                if (dn != '0) state_next = leb_pkg::ST_DEL;
                            end
                        end
                        leb_pkg::CMD_SELALL: begin
                            if (active && len_reg != '0) begin
                                all_next = 1'b1;
                                ss_next  = '0;
                                se_next  = len_reg;
                                cur_next = len_reg;
                            end
                        end
                        leb_pkg::CMD_COPY, leb_pkg::CMD_CUT: begin
                            if (active && (all_reg || ss_reg != se_reg)) begin
                                // The text ends the copy sweep where it began; only
                                // the scalar registers move ahead of it.
                                clip_next   = ce - cs;
                                s_next      = cs;
                                e_next      = ce;
                                state_next  = leb_pkg::ST_COPY;
                                cutdel_next = 1'b0;
                                if (kind_in == leb_pkg::CMD_CUT && ce != cs) begin
                                    ss_next  = '0;
                                    se_next  = '0;
                                    all_next = 1'b0;
                                    if (all_reg) begin
                                        len_next = '0;
                                        cur_next = '0;
                                    end else begin
                                        len_next    = len_reg - (ce - cs);
                                        cur_next    = cs;
                                        base_next   = cs;
                                        n_next      = ce - cs;
                                        cutdel_next = 1'b1;
                                    end
                                end
                            end
                        end
                        leb_pkg::CMD_SUBMIT: begin
                            if (active) mode_next = leb_pkg::MODE_SUBMITTED;
                        end
                        leb_pkg::CMD_CANCEL: begin
                            mode_next = leb_pkg::MODE_CANCELLED;
                            acc_next  = 1'b1;
                        end
                        leb_pkg::CMD_READ: begin
                            acc_next   = 1'b1;
                            state_next = leb_pkg::ST_READ;
                        end
                        default: state_next = leb_pkg::ST_FIN;
                    endcase
                end
            end
            leb_pkg::ST_DEL: begin
                t_op     = leb_pkg::OP_SHL;
                t_base   = base_reg;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(n_reg - XW'(1))) begin
                    cnt_next = '0;
                    case (kind_reg)
                        leb_pkg::CMD_INSERT: state_next = leb_pkg::ST_INS;
                        leb_pkg::CMD_PASTE:  state_next = leb_pkg::ST_PCHK;
                        default:             state_next = leb_pkg::ST_FIN;
                    endcase
                end
            end
            leb_pkg::ST_INS: begin
                state_next = leb_pkg::ST_FIN;
                if (len_reg >= lim) begin
                    acc_next = 1'b0;
                end else begin
                    t_op     = leb_pkg::OP_INS;
                    t_base   = pos_c;
                    t_din    = ch_reg;
                    len_next = len_reg + XW'(1);
                    cur_next = pos_c + XW'(1);
                end
            end
            leb_pkg::ST_PCHK: begin
                cnt_next = '0;
                if (pn == '0) begin
                    state_next = leb_pkg::ST_FIN;
                end else begin
                    base_next  = pos_c;
                    n_next     = pn;
                    len_next   = len_reg + pn;
                    cur_next   = pos_c + pn;
                    state_next = leb_pkg::ST_PASTE;
                end
            end
            leb_pkg::ST_PASTE: begin
                // The clipboard turns one full lap; its head is dropped in
                // at the next insert position while characters remain.
                c_op     = leb_pkg::OP_SHL;
                c_tail   = cq[0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg < CW'(n_reg)) begin
                    t_op   = leb_pkg::OP_INS;
                    t_base = base_reg + cnt_reg[XW-1:0];
                    t_din  = cq[0];
                end
                if (cnt_reg == LAST_ONE) state_next = leb_pkg::ST_FIN;
            end
            leb_pkg::ST_COPY: begin
                // The text turns two laps; the clipboard turns one lap that
                // starts when the first selected character reaches the head.
                t_op     = leb_pkg::OP_SHL;
                t_base   = '0;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg >= CW'(s_reg) && cnt_reg < CW'(s_reg) + CW'(MAX_CHARS)) begin
                    c_op   = leb_pkg::OP_SHL;
                    c_tail = (cnt_reg < CW'(e_reg)) ? tq[0] : cq[0];
                end
                if (cnt_reg == LAST_TWO) begin
                    cnt_next   = '0;
                    state_next = cutdel_reg ? leb_pkg::ST_DEL : leb_pkg::ST_FIN;
                end
            end
            leb_pkg::ST_READ: begin
                t_op     = leb_pkg::OP_SHL;
                t_base   = '0;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ridx_reg) && XW'(ridx_reg) < len_reg) rch_next = tq[0];
                if (cnt_reg == LAST_ONE) state_next = leb_pkg::ST_FIN;
            end
            leb_pkg::ST_FIN: begin
                if (!m_tvalid_reg || m_tready) state_next = leb_pkg::ST_IDLE;
            end
            default: state_next = leb_pkg::ST_IDLE;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CHARS; gi++) begin : g_cells
            leb_cell #(.W(DW), .XW(XW), .IDX(gi)) u_text (
                .aclk  (aclk),
                .op    (t_op),
                .base  (t_base),
                .din   (t_din),
                .left  ((gi == 0) ? tq[0] : tq[(gi == 0) ? 0 : gi - 1]),
                .right ((gi == MAX_CHARS - 1) ? tq[0] : tq[(gi == MAX_CHARS - 1) ? 0 : gi + 1]),
                .q     (tq[gi])
            );
            leb_cell #(.W(DW), .XW(XW), .IDX(gi)) u_clip (
                .aclk  (aclk),
                .op    (c_op),
                .base  ('0),
                .din   (c_tail),
                .left  ((gi == 0) ? cq[0] : cq[(gi == 0) ? 0 : gi - 1]),
                .right ((gi == MAX_CHARS - 1) ? c_tail : cq[(gi == MAX_CHARS - 1) ? 0 : gi + 1]),
                .q     (cq[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= leb_pkg::ST_IDLE;
            mode_reg     <= leb_pkg::MODE_ACTIVE;
            len_reg      <= '0;
            cur_reg      <= '0;
            ss_reg       <= '0;
            se_reg       <= '0;
            all_reg      <= 1'b0;
            clip_reg     <= '0;
            maxlen_reg   <= leb_pkg::MAX_LEN_RESET;
            cnt_reg      <= '0;
            cutdel_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            cur_reg    <= cur_next;
            ss_reg     <= ss_next;
            se_reg     <= se_next;
            all_reg    <= all_next;
            clip_reg   <= clip_next;
            cnt_reg    <= cnt_next;
            cutdel_reg <= cutdel_next;
            if (cfg_valid && cfg_ready) maxlen_reg <= cfg_data;
            if (state_reg == leb_pkg::ST_FIN && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        rch_reg  <= rch_next;
        base_reg <= base_next;
        n_reg    <= n_next;
        s_reg    <= s_next;
        e_reg    <= e_next;
        if (in_fire) begin
            kind_reg <= kind_in;
            ch_reg   <= s_tdata[15:0];
            ridx_reg <= s_tdata[41:34];
        end
        if (state_reg == leb_pkg::ST_FIN && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {7'd0, rch_reg, clip_reg[8:0], all_reg, se_reg[8:0],
                            ss_reg[8:0], cur_reg[8:0], len_reg[8:0], mode_reg, acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAXP)
        else $error("text length beyond capacity");

    a_cur_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= len_reg)
        else $error("cursor past end of text");

    a_clip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        clip_reg <= MAXP)
        else $error("clipboard length beyond capacity");

    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == leb_pkg::ST_DEL |-> (n_reg != '0 && cnt_reg < CW'(n_reg)))
        else $error("delete sweep overran its count");

endmodule

// ----- test/tb_line_edit_buffer_top.sv -----
module tb_line_edit_buffer_top;

    localparam int NCH = leb_pkg::MAX_CHARS_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        acc;
        logic [1:0]  state;
        logic [8:0]  len;
        logic [8:0]  cur;
        logic [8:0]  lo;
        logic [8:0]  hi;
        logic        all;
        logic [8:0]  clip;
        logic [15:0] rch;
    } edit_res_t;

    typedef struct {
        leb_pkg::cmd_t kind;
        logic [15:0]   ch;
        logic [8:0]    a;
        logic [8:0]    b;
        logic [7:0]    ridx;
        bit            typed;
        edit_res_t     res;
    } cmd_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;

    always #2 aclk = ~aclk;

    line_edit_buffer_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Shadow copy of the editor state.
    logic [15:0]    txt_mem [NCH];
    logic [15:0]    clip_mem [NCH];
    int             txt_len, cur_pos, sel_s, sel_e, clip_len;
    bit             all_sel;
    leb_pkg::mode_t sess;
    int             max_len_cfg = 256;

    edit_res_t   pending_res[$];
    int          err_cnt = 0;
    int          cycles = 0;
    bit          hold_req = 1'b0;
    bit          final_phase = 1'b0;

    function automatic int line_limit();
        int m;
        m = max_len_cfg;
        if (m < 1) m = 1;
        if (m > NCH) m = NCH;
        return m;
    endfunction

    function automatic void clear_text();
        txt_len = 0; cur_pos = 0; all_sel = 0; sel_s = 0; sel_e = 0;
    endfunction

    function automatic void remove_range();
        int s, e, n, t;
        s = sel_s; e = sel_e;
        if (s == e) return;
        if (s > e) begin t = s; s = e; e = t; end
        if (e > txt_len) e = txt_len;
        if (s > txt_len) return;
        n = e - s;
        for (int i = s; i + n < txt_len; i++) txt_mem[i] = txt_mem[i + n];
        txt_len -= n;
        cur_pos = s; sel_s = 0; sel_e = 0; all_sel = 0;
    endfunction

    function automatic void drop_sel();
        if (all_sel) clear_text();
        else if (sel_s != sel_e) remove_range();
    endfunction

    function automatic void copy_sel();
        int s, e, t;
        if (all_sel) begin
            s = 0; e = txt_len;
        end else if (sel_s != sel_e) begin
            s = sel_s; e = sel_e;
            if (s > e) begin t = s; s = e; e = t; end
            if (e > txt_len) e = txt_len;
            if (s > e) s = e;
        end else begin
            return;
        end
        for (int i = 0; i < e - s; i++) clip_mem[i] = txt_mem[s + i];
        clip_len = e - s;
    endfunction

    function automatic void paste_clip();
        int room, n, p, lim;
        if (clip_len == 0) return;
        drop_sel();
        lim = line_limit();
        room = (txt_len < lim) ? lim - txt_len : 0;
        n = (clip_len > room) ? room : clip_len;
        if (n == 0) return;
        p = (cur_pos > txt_len) ? txt_len : cur_pos;
        for (int i = txt_len; i > p; i--) txt_mem[i + n - 1] = txt_mem[i - 1];
        for (int i = 0; i < n; i++) txt_mem[p + i] = clip_mem[i];
        txt_len += n;
        cur_pos = p + n;
    endfunction

    function automatic edit_res_t apply_cmd(leb_pkg::cmd_t k, logic [15:0] ch, int a, int b,
                                            int ridx);
        edit_res_t r;
        bit act;
        int p, t;
        logic [15:0] rch;
        act = (sess == leb_pkg::MODE_ACTIVE);
        r.acc = act;
        rch = '0;
        case (k)
            leb_pkg::CMD_INSERT: if (act) begin
                drop_sel();
                if (txt_len >= line_limit()) begin
                    r.acc = 0;
                end else begin
                    p = (cur_pos > txt_len) ? txt_len : cur_pos;
                    for (int i = txt_len; i > p; i--) txt_mem[i] = txt_mem[i - 1];
                    txt_mem[p] = ch;
                    txt_len++;
                    cur_pos = p + 1;
                end
            end
            leb_pkg::CMD_BACKSPACE: if (act) begin
                if (all_sel) clear_text();
                else if (sel_s != sel_e) remove_range();
                else if (cur_pos == 0 || txt_len == 0) r.acc = 0;
                else begin
                    p = cur_pos - 1;
                    if (p >= txt_len) p = txt_len - 1;
                    for (int i = p; i + 1 < txt_len; i++) txt_mem[i] = txt_mem[i + 1];
                    txt_len--;
                    cur_pos = p;
                end
            end
            leb_pkg::CMD_LEFT: if (act) begin
                all_sel = 0;
                if (cur_pos > 0) cur_pos--;
            end
            leb_pkg::CMD_RIGHT: if (act) begin
                all_sel = 0;
                if (cur_pos < txt_len) cur_pos++;
            end
            leb_pkg::CMD_HOME: if (act) begin all_sel = 0; cur_pos = 0; end
            leb_pkg::CMD_END: if (act) begin all_sel = 0; cur_pos = txt_len; end
            leb_pkg::CMD_SETSEL: if (act) begin
                if (a > txt_len) a = txt_len;
                if (b > txt_len) b = txt_len;
                if (a > b) begin t = a; a = b; b = t; end
                sel_s = a; sel_e = b; all_sel = 0;
            end
            leb_pkg::CMD_CLEARSEL: begin sel_s = 0; sel_e = 0; all_sel = 0; r.acc = 1; end
            leb_pkg::CMD_DELSEL: if (act) remove_range();
            leb_pkg::CMD_SELALL: if (act && txt_len != 0) begin
                all_sel = 1; sel_s = 0; sel_e = txt_len; cur_pos = txt_len;
            end
            leb_pkg::CMD_COPY: if (act) copy_sel();
            leb_pkg::CMD_CUT: if (act) begin
                copy_sel();
                if (clip_len > 0) begin
                    if (all_sel) clear_text();
                    else remove_range();
                end
            end
            leb_pkg::CMD_PASTE: if (act) paste_clip();
            leb_pkg::CMD_SUBMIT: if (act) sess = leb_pkg::MODE_SUBMITTED;
            leb_pkg::CMD_CANCEL: begin sess = leb_pkg::MODE_CANCELLED; r.acc = 1; end
            default: begin
                if (ridx < txt_len) rch = txt_mem[ridx];
                r.acc = 1;
            end
        endcase
        r.state = sess;
        r.len = txt_len[8:0];
        r.cur = cur_pos[8:0];
        r.lo = sel_s[8:0];
        r.hi = sel_e[8:0];
        r.all = all_sel;
        r.clip = clip_len[8:0];
        r.rch = rch;
        return r;
    endfunction

    function automatic edit_res_t mk_res(bit acc, int len, int cur, logic [15:0] rch);
        edit_res_t r;
        r = '0;
        r.acc = acc; r.len = len[8:0]; r.cur = cur[8:0]; r.rch = rch;
        return r;
    endfunction

    task automatic send_cmd(cmd_row_t c, int gap);
        edit_res_t pr;
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= c.kind;
        s_tdata <= {6'd0, c.ridx, c.b, c.a, c.ch};
        do @(posedge aclk); while (!s_tready);
        pr = apply_cmd(c.kind, c.ch, c.a, c.b, c.ridx);
        pending_res.push_back(c.typed ? c.res : pr);
    endtask

    task automatic write_max_len(logic [8:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        max_len_cfg = v;
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic cmd_row_t rand_cmd();
        cmd_row_t c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) c.kind = leb_pkg::CMD_INSERT;
        else if (final_phase) c.kind = leb_pkg::cmd_t'($urandom_range(0, 15));
        else begin
            c.kind = leb_pkg::cmd_t'($urandom_range(1, 13));
            if (c.kind == leb_pkg::CMD_SUBMIT) c.kind = leb_pkg::CMD_READ;
        end
        c.ch = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) != 0) begin
            c.a = 9'($urandom_range(0, txt_len));
            c.b = 9'($urandom_range(0, txt_len));
        end else begin
            c.a = 9'($urandom_range(0, 511));
            c.b = 9'($urandom_range(0, 511));
        end
        if (txt_len > 0 && $urandom_range(0, 3) != 0) c.ridx = 8'($urandom_range(0, txt_len - 1));
        else c.ridx = 8'($urandom_range(0, 255));
        c.typed = 0;
        c.res = '0;
        return c;
    endfunction

    task automatic run_random(int n, bit pressure);
        for (int i = 0; i < n; i++) begin
            if (pressure && i == 40) hold_req = 1'b1;
            if (pressure && i == 150) wait_drained();
            send_cmd(rand_cmd(), (i % 64 < 16) ? 0 : pick_gap());
        end
    endtask

    function automatic cmd_row_t row(leb_pkg::cmd_t k, logic [15:0] ch, logic [8:0] a,
                                     logic [8:0] b, logic [7:0] ridx, bit typed,
                                     edit_res_t r);
        cmd_row_t c;
        c.kind = k; c.ch = ch; c.a = a; c.b = b; c.ridx = ridx; c.typed = typed; c.res = r;
        return c;
    endfunction

    // Result channel back-pressure; a long hold-off is counted here on request.
    initial begin
        forever begin
            if (hold_req) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (3000) @(negedge aclk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (pick_gap()) @(negedge aclk);
            end else begin
                @(negedge aclk) m_tready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(negedge aclk);
            end
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        edit_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_res.size() == 0) begin
                $error("result beat with no command outstanding");
                err_cnt++;
            end else begin
                e = pending_res.pop_front();
                check_field("accepted", e.acc, m_tdata[0]);
                check_field("session_state", e.state, m_tdata[2:1]);
                check_field("text_length", e.len, m_tdata[11:3]);
                check_field("cursor_pos", e.cur, m_tdata[20:12]);
                check_field("sel_lo", e.lo, m_tdata[29:21]);
                check_field("sel_hi", e.hi, m_tdata[38:30]);
                check_field("all_selected", e.all, m_tdata[39]);
                check_field("clip_length", e.clip, m_tdata[48:40]);
                check_field("read_char", e.rch, m_tdata[64:49]);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        cmd_row_t dir[$];
        edit_res_t z;
        z = '0;
        clear_text();
        clip_len = 0;
        sess = leb_pkg::MODE_ACTIVE;
        for (int i = 0; i < NCH; i++) begin txt_mem[i] = '0; clip_mem[i] = '0; end

        dir.push_back(row(leb_pkg::CMD_READ, 16'h0, 9'd0, 9'd0, 8'd0, 1,
                          mk_res(1, 0, 0, 0)));
        dir.push_back(row(leb_pkg::CMD_BACKSPACE, 16'h0, 9'd0, 9'd0, 8'd0, 1,
                          mk_res(0, 0, 0, 0)));
        dir.push_back(row(leb_pkg::CMD_LEFT, 16'h0, 9'd0, 9'd0, 8'd0, 1,
                          mk_res(1, 0, 0, 0)));
        dir.push_back(row(leb_pkg::CMD_SELALL, 16'h0, 9'd0, 9'd0, 8'd0, 1,
                          mk_res(1, 0, 0, 0)));
        dir.push_back(row(leb_pkg::CMD_PASTE, 16'h0, 9'd0, 9'd0, 8'd0, 1,
                          mk_res(1, 0, 0, 0)));
        dir.push_back(row(leb_pkg::CMD_INSERT, 16'hFFFF, 9'd0, 9'd0, 8'd0, 1,
                          mk_res(1, 1, 1, 0)));
        dir.push_back(row(leb_pkg::CMD_READ, 16'h0, 9'd0, 9'd0, 8'd0, 1,
                          mk_res(1, 1, 1, 16'hFFFF)));
        dir.push_back(row(leb_pkg::CMD_INSERT, 16'h0000, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_INSERT, 16'hA5A5, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_HOME, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_RIGHT, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_END, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_SETSEL, 16'h0, 9'd511, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_COPY, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_READ, 16'h0, 9'd0, 9'd0, 8'd255, 0, z));
        dir.push_back(row(leb_pkg::CMD_CUT, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_PASTE, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_PASTE, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_SETSEL, 16'h0, 9'd2, 9'd1, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_DELSEL, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_SELALL, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_COPY, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_BACKSPACE, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_PASTE, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_SETSEL, 16'h0, 9'd0, 9'd1, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_INSERT, 16'h5A5A, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_CLEARSEL, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_HOME, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));
        dir.push_back(row(leb_pkg::CMD_BACKSPACE, 16'h0, 9'd0, 9'd0, 8'd0, 0, z));

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir[i]) send_cmd(dir[i], pick_gap());
        run_random(280, 1);

        // Shrinking the limit under the current text keeps the text but blocks growth.
        wait_drained(); write_max_len(9'd1);   run_random(80, 0);
        wait_drained(); write_max_len(9'd2);   run_random(80, 0);
        wait_drained(); write_max_len(9'd0);   run_random(60, 0);
        wait_drained(); write_max_len(9'd511); run_random(80, 0);
        wait_drained(); write_max_len(9'($urandom_range(3, 255))); run_random(200, 0);
        wait_drained(); write_max_len(9'd256); run_random(150, 0);

        // Ending the session is permanent without a reset, so it comes last.
        send_cmd(row(leb_pkg::CMD_SUBMIT, 16'h0, 9'd0, 9'd0, 8'd0, 0, z), 0);
        final_phase = 1'b1;
        run_random(40, 0);
        send_cmd(row(leb_pkg::CMD_CANCEL, 16'h0, 9'd0, 9'd0, 8'd0, 0, z), 0);
        run_random(30, 0);

        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/leb_pkg.sv
sv/leb_cell.sv
sv/line_edit_buffer_top.sv
test/tb_line_edit_buffer_top.sv
